// ===== design/bba_pkg.sv =====
package bba_pkg;

  localparam int MAX_POOL_ORDER  = 16;
  localparam int MIN_BLOCK_ORDER = 5;
  localparam int HEADER_BYTES    = 24;
  localparam int POOL_ORDER_RESET = 16;

  localparam int OFF_W  = 16;
  localparam int REQ_W  = 16;
  localparam int ORD_W  = 5;
  localparam int TAG_W  = ORD_W + 1;
  localparam int GRAN_W = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
  localparam int GRANULES = 1 << GRAN_W;
  localparam int TOT_W  = REQ_W + 1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_LAST    = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_SPLIT,
    S_RSCAN,
    S_FCHK0,
    S_FRD,
    S_FCHK,
    S_FFIN
  } bba_state_t;

  typedef struct packed {
    logic                 is_free;
    logic                 reject;
    logic [ORD_W-1:0]     need;
    logic [GRAN_W-1:0]    gran;
  } bba_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bba_qstat_t;

endpackage

// ===== design/bba_front.sv =====
module bba_front (
  input  logic                        in_cmd,
  input  logic [bba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]   in_release_offset,
  input  logic [bba_pkg::ORD_W-1:0]   pool_order,
  output bba_pkg::bba_job_t           job
);

  logic [bba_pkg::TOT_W-1:0]  total;
  logic [bba_pkg::TOT_W-1:0]  tm1;
  logic [bba_pkg::ORD_W-1:0]  need;
  logic [bba_pkg::OFF_W-1:0]  bs;
  logic [bba_pkg::GRAN_W-1:0] gran;
  logic [bba_pkg::GRAN_W-1:0] mask;
  logic                       bad;

  always_comb begin
    total = {1'b0, in_request_bytes} + bba_pkg::TOT_W'(bba_pkg::HEADER_BYTES);
    tm1   = total - bba_pkg::TOT_W'(1);
    need  = bba_pkg::ORD_W'(bba_pkg::MIN_BLOCK_ORDER);
    for (int i = 0; i < bba_pkg::TOT_W; i++) begin
      if (tm1[i] && (i + 1 > bba_pkg::MIN_BLOCK_ORDER)) need = bba_pkg::ORD_W'(i + 1);
    end
    mask = bba_pkg::GRAN_W'((({(bba_pkg::GRAN_W+1){1'b0}} | 1'b1)
           << (pool_order - bba_pkg::ORD_W'(bba_pkg::MIN_BLOCK_ORDER))) - 1'b1);
    bs   = in_release_offset - bba_pkg::OFF_W'(bba_pkg::HEADER_BYTES);
    gran = bs[bba_pkg::OFF_W-1 -: bba_pkg::GRAN_W];
    bad  = (in_release_offset < bba_pkg::OFF_W'(bba_pkg::HEADER_BYTES))
        || (bs[bba_pkg::MIN_BLOCK_ORDER-1:0] != '0)
        || ((gran & ~mask) != '0);

    job.is_free = (in_cmd == bba_pkg::CMD_FREE);
    job.need    = need;
    job.gran    = gran;
    job.reject  = (in_cmd == bba_pkg::CMD_FREE) ? bad : (need > pool_order);
  end

endmodule

// ===== design/bba_queue.sv =====
module bba_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bba_pkg::bba_job_t  push_job,
  input  logic               pop,
  output bba_pkg::bba_job_t  head,
  output bba_pkg::bba_qstat_t stat
);

  bba_pkg::bba_job_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    head    = slot_r[rp_r];
    stat.full  = (cnt_r == 2'd2);
    stat.empty = (cnt_r == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wp_r] <= push_job;
  end

endmodule

// ===== design/bba_back.sv =====
module bba_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bba_pkg::ORD_W-1:0]   cfg_wdata,
  input  bba_pkg::bba_job_t           job,
  input  logic                        job_valid,
  output logic                        job_pop,
  output logic [bba_pkg::ORD_W-1:0]   pool_order,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [bba_pkg::OFF_W-1:0]   out_payload_offset,
  output logic [bba_pkg::ORD_W-1:0]   out_granted_order
);

  localparam int GW = bba_pkg::GRAN_W;
  localparam int OW = bba_pkg::ORD_W;
  localparam int TW = bba_pkg::TAG_W;

  logic [TW-1:0] mem [bba_pkg::GRANULES];
  logic [TW-1:0] rdata_r;
  logic [GW-1:0] raddr, waddr;
  logic [TW-1:0] wdata;
  logic          we;

  bba_pkg::bba_state_t state_r, state_nxt;
  logic [OW-1:0] po_r, po_nxt;
  logic [GW-1:0] rover_r, rover_nxt;
  logic [GW-1:0] clr_r, clr_nxt;
  logic [GW:0]   k_r, k_nxt;
  logic [GW-1:0] base_r, base_nxt;
  logic          pend_r, pend_nxt;
  logic [GW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [1:0]    frees_r, frees_nxt;
  logic [GW-1:0] g_r, g_nxt;
  logic [OW-1:0] ord_r, ord_nxt;
  logic [OW-1:0] need_r, need_nxt;
  logic [GW-1:0] bud_r, bud_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [bba_pkg::OFF_W-1:0] oo_r, oo_nxt;
  logic [OW-1:0] og_r, og_nxt;

  logic [GW:0]   n;
  logic [GW-1:0] mask;
  logic          fh;
  logic [OW-1:0] clamp;
  logic [OW-1:0] shamt;

  always_comb begin
    n     = (GW+1)'(1) << (po_r - OW'(bba_pkg::MIN_BLOCK_ORDER));
    mask  = GW'(n - 1'b1);
    fh    = (rdata_r[OW-1:0] != '0) && !rdata_r[OW];
    clamp = cfg_wdata;
    if (clamp > OW'(bba_pkg::MAX_POOL_ORDER)) clamp = OW'(bba_pkg::MAX_POOL_ORDER);
    if (clamp < OW'(bba_pkg::MIN_BLOCK_ORDER)) clamp = OW'(bba_pkg::MIN_BLOCK_ORDER);

    state_nxt = state_r;
    po_nxt    = po_r;
    rover_nxt = rover_r;
    clr_nxt   = clr_r;
    k_nxt     = k_r;
    base_nxt  = base_r;
    pend_nxt  = 1'b0;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    frees_nxt = frees_r;
    g_nxt     = g_r;
    ord_nxt   = ord_r;
    need_nxt  = need_r;
    bud_nxt   = bud_r;
    ov_nxt    = ov_r && out_stall;
    os_nxt    = os_r;
    oo_nxt    = oo_r;
    og_nxt    = og_r;
    raddr     = '0;
    waddr     = '0;
    wdata     = '0;
    we        = 1'b0;
    job_pop   = 1'b0;
    shamt     = '0;

    if (state_r == bba_pkg::S_SCAN || state_r == bba_pkg::S_RSCAN) begin
      if (k_r < n) begin
        raddr    = (base_r + GW'(k_r)) & mask;
        pend_nxt = 1'b1;
        idx_nxt  = raddr;
        k_nxt    = k_r + 1'b1;
      end
    end

    unique case (state_r)
      bba_pkg::S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = (clr_r == '0) ? {1'b0, po_r} : '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (job_valid && !ov_r) begin
          job_pop  = 1'b1;
          need_nxt = job.need;
          g_nxt    = job.gran;
          if (job.reject) begin
            ov_nxt = 1'b1;
            os_nxt = job.is_free ? bba_pkg::ST_BADFREE : bba_pkg::ST_NOFIT;
            oo_nxt = '0;
            og_nxt = '0;
          end else if (job.is_free) begin
            raddr     = job.gran;
            state_nxt = bba_pkg::S_FCHK0;
          end else begin
            base_nxt  = rover_r & mask;
            k_nxt     = '0;
            found_nxt = 1'b0;
            frees_nxt = '0;
            state_nxt = bba_pkg::S_SCAN;
          end
        end
      end
      bba_pkg::S_SCAN: begin
        if (pend_r && fh) begin
          if (frees_r != 2'd2) frees_nxt = frees_r + 1'b1;
          if (!found_r && rdata_r[OW-1:0] >= need_r) begin
            found_nxt = 1'b1;
            g_nxt     = idx_r;
            ord_nxt   = rdata_r[OW-1:0];
          end
        end
        if ((found_r && frees_r == 2'd2) || (k_r == n && !pend_r)) begin
          pend_nxt = 1'b0;
          if (!found_r) begin
            ov_nxt    = 1'b1;
            os_nxt    = bba_pkg::ST_NOFIT;
            oo_nxt    = '0;
            og_nxt    = '0;
            state_nxt = bba_pkg::S_IDLE;
          end else begin
            rover_nxt = g_r;
            if (ord_r == need_r && frees_r == 2'd1) begin
              ov_nxt    = 1'b1;
              os_nxt    = bba_pkg::ST_LAST;
              oo_nxt    = '0;
              og_nxt    = '0;
              state_nxt = bba_pkg::S_IDLE;
            end else begin
              state_nxt = bba_pkg::S_SPLIT;
            end
          end
        end
      end
      bba_pkg::S_SPLIT: begin
        we = 1'b1;
        if (ord_r > need_r) begin
          shamt   = ord_r - OW'(bba_pkg::MIN_BLOCK_ORDER + 1);
          waddr   = g_r + (GW'(1) << shamt);
          wdata   = {1'b0, ord_r - 1'b1};
          ord_nxt = ord_r - 1'b1;
        end else begin
          waddr     = g_r;
          wdata     = {1'b1, ord_r};
          base_nxt  = g_r;
          k_nxt     = (GW+1)'(1);
          state_nxt = bba_pkg::S_RSCAN;
        end
      end
      bba_pkg::S_RSCAN: begin
        if ((pend_r && fh) || (k_r == n && !pend_r)) begin
          if (pend_r && fh) rover_nxt = idx_r;
          pend_nxt  = 1'b0;
          ov_nxt    = 1'b1;
          os_nxt    = bba_pkg::ST_OK;
          oo_nxt    = {g_r, {bba_pkg::MIN_BLOCK_ORDER{1'b0}}}
                      + bba_pkg::OFF_W'(bba_pkg::HEADER_BYTES);
          og_nxt    = ord_r;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_FCHK0: begin
        if (!fh && rdata_r[OW-1:0] != '0) begin
          ord_nxt   = rdata_r[OW-1:0];
          state_nxt = (rdata_r[OW-1:0] < po_r) ? bba_pkg::S_FRD : bba_pkg::S_FFIN;
        end else begin
          ov_nxt    = 1'b1;
          os_nxt    = bba_pkg::ST_BADFREE;
          oo_nxt    = '0;
          og_nxt    = '0;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_FRD: begin
        shamt     = ord_r - OW'(bba_pkg::MIN_BLOCK_ORDER);
        bud_nxt   = g_r ^ (GW'(1) << shamt);
        raddr     = bud_nxt;
        state_nxt = bba_pkg::S_FCHK;
      end
      bba_pkg::S_FCHK: begin
        if (rdata_r == {1'b0, ord_r}) begin
          we        = 1'b1;
          wdata     = '0;
          waddr     = (bud_r < g_r) ? g_r : bud_r;
          g_nxt     = (bud_r < g_r) ? bud_r : g_r;
          ord_nxt   = ord_r + 1'b1;
          state_nxt = (ord_nxt < po_r) ? bba_pkg::S_FRD : bba_pkg::S_FFIN;
        end else begin
          state_nxt = bba_pkg::S_FFIN;
        end
      end
      bba_pkg::S_FFIN: begin
        we        = 1'b1;
        waddr     = g_r;
        wdata     = {1'b0, ord_r};
        rover_nxt = g_r;
        ov_nxt    = 1'b1;
        os_nxt    = bba_pkg::ST_OK;
        oo_nxt    = '0;
        og_nxt    = ord_r;
        state_nxt = bba_pkg::S_IDLE;
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase

    if (cfg_we) begin
      po_nxt    = clamp;
      clr_nxt   = '0;
      rover_nxt = '0;
      state_nxt = bba_pkg::S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLR;
      po_r    <= OW'(bba_pkg::POOL_ORDER_RESET);
      rover_r <= '0;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      po_r    <= po_nxt;
      rover_r <= rover_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    k_r     <= k_nxt;
    base_r  <= base_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    frees_r <= frees_nxt;
    g_r     <= g_nxt;
    ord_r   <= ord_nxt;
    need_r  <= need_nxt;
    bud_r   <= bud_nxt;
    os_r    <= os_nxt;
    oo_r    <= oo_nxt;
    og_r    <= og_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign pool_order         = po_r;
  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_payload_offset = oo_r;
  assign out_granted_order  = og_r;

endmodule

// ===== design/buddy_block_allocator_top.sv =====
// Buddy allocator over a 2^pool_order byte pool, tracked in 32-byte granules
// by a 2048-entry tag memory. Requests are classified on entry and queued
// (two deep), then executed one at a time. An allocate scans the tags from
// the rover over the n granules of the pool (up to 2048), then splits the
// found block and runs the rover search after it; the scan stops early once a
// fit and a second free block are seen. A free checks the block's tag, then
// reads each buddy and merges while it is free and of the same order.
// After reset and after every cfg write all 2048 tag memory entries are
// cleared, during which no request is executed (requests still queue).
module buddy_block_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bba_pkg::ORD_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [bba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]   in_release_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [bba_pkg::OFF_W-1:0]   out_payload_offset,
  output logic [bba_pkg::ORD_W-1:0]   out_granted_order
);

  bba_pkg::bba_job_t   fjob, hjob;
  bba_pkg::bba_qstat_t qstat;
  logic                pop;
  logic [bba_pkg::ORD_W-1:0] pool_order;

  bba_front u_front (
    .in_cmd            (in_cmd),
    .in_request_bytes  (in_request_bytes),
    .in_release_offset (in_release_offset),
    .pool_order        (pool_order),
    .job               (fjob)
  );

  assign in_stall = qstat.full;

  bba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !qstat.full),
    .push_job (fjob),
    .pop      (pop),
    .head     (hjob),
    .stat     (qstat)
  );

  bba_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .job                (hjob),
    .job_valid          (!qstat.empty),
    .job_pop            (pop),
    .pool_order         (pool_order),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_granted_order  (out_granted_order)
  );

endmodule

// ===== bench/buddy_block_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module buddy_block_allocator_top_tb;

  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [1:0]                status;
    logic [bba_pkg::OFF_W-1:0] offset;
    logic [bba_pkg::ORD_W-1:0] order;
  } grant_t;

  typedef struct {
    logic                      cmd;
    logic [bba_pkg::REQ_W-1:0] req;
    logic [bba_pkg::OFF_W-1:0] rel;
    bit                        typed;
    grant_t                    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bba_pkg::ORD_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = bba_pkg::CMD_ALLOC;
  logic [bba_pkg::REQ_W-1:0] in_request_bytes = '0;
  logic [bba_pkg::OFF_W-1:0] in_release_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [bba_pkg::OFF_W-1:0] out_payload_offset;
  logic [bba_pkg::ORD_W-1:0] out_granted_order;

  logic [bba_pkg::TAG_W-1:0] tags [bba_pkg::GRANULES];
  logic [bba_pkg::GRAN_W-1:0] rover;
  int pool_ord;
  grant_t grants_due[$];
  int live_offsets[$];
  int errors = 0;
  int cycles = 0;
  int tx_gap_max = 3;

  buddy_block_allocator_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_request_bytes(in_request_bytes), .in_release_offset(in_release_offset),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_payload_offset(out_payload_offset), .out_granted_order(out_granted_order)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void pool_reset(input int ord);
    for (int i = 0; i < bba_pkg::GRANULES; i++) tags[i] = '0;
    pool_ord = ord;
    tags[0] = bba_pkg::TAG_W'(ord);
    rover = '0;
    live_offsets.delete();
  endfunction

  function automatic bit free_head(input int g);
    return tags[g][bba_pkg::ORD_W-1:0] != 0 && !tags[g][bba_pkg::ORD_W];
  endfunction

  function automatic grant_t predict_alloc(input logic [bba_pkg::REQ_W-1:0] req);
    grant_t r;
    int total, need, n, first, g, frees, ord, i;
    bit found;
    r = '{bba_pkg::ST_NOFIT, '0, '0};
    total = bba_pkg::HEADER_BYTES + req;
    need = bba_pkg::MIN_BLOCK_ORDER;
    n = 1 << (pool_ord - bba_pkg::MIN_BLOCK_ORDER);
    first = rover & (n - 1);
    found = 0;
    frees = 0;
    g = 0;
    while ((1 << need) < total) need++;
    if (need > pool_ord) return r;
    for (int k = 0; k < n; k++) begin
      i = (first + k) & (n - 1);
      if (free_head(i)) begin
        frees++;
        if (!found && tags[i][bba_pkg::ORD_W-1:0] >= need) begin
          found = 1;
          g = i;
        end
      end
    end
    if (!found) return r;
    rover = bba_pkg::GRAN_W'(g);
    ord = tags[g][bba_pkg::ORD_W-1:0];
    if (ord == need && frees == 1) begin
      r.status = bba_pkg::ST_LAST;
      return r;
    end
    while (ord > need) begin
      ord--;
      tags[g + (1 << (ord - bba_pkg::MIN_BLOCK_ORDER))] = bba_pkg::TAG_W'(ord);
    end
    tags[g] = bba_pkg::TAG_W'(ord | (1 << bba_pkg::ORD_W));
    for (int k = 1; k < n; k++) begin
      i = (g + k) & (n - 1);
      if (free_head(i)) begin
        rover = bba_pkg::GRAN_W'(i);
        break;
      end
    end
    r = '{bba_pkg::ST_OK,
          bba_pkg::OFF_W'((g << bba_pkg::MIN_BLOCK_ORDER) + bba_pkg::HEADER_BYTES),
          bba_pkg::ORD_W'(ord)};
    live_offsets.push_back(int'(r.offset));
    return r;
  endfunction

  function automatic grant_t predict_release(input logic [bba_pkg::OFF_W-1:0] off);
    grant_t r;
    int bstart, g, ord, bud;
    r = '{bba_pkg::ST_BADFREE, '0, '0};
    if (off < bba_pkg::HEADER_BYTES) return r;
    bstart = off - bba_pkg::HEADER_BYTES;
    if ((bstart % (1 << bba_pkg::MIN_BLOCK_ORDER)) != 0 ||
        (bstart >> bba_pkg::MIN_BLOCK_ORDER) >=
        (1 << (pool_ord - bba_pkg::MIN_BLOCK_ORDER)))
      return r;
    g = bstart >> bba_pkg::MIN_BLOCK_ORDER;
    if (tags[g][bba_pkg::ORD_W-1:0] == 0 || !tags[g][bba_pkg::ORD_W]) return r;
    ord = tags[g][bba_pkg::ORD_W-1:0];
    tags[g] = bba_pkg::TAG_W'(ord);
    while (ord < pool_ord) begin
      bud = g ^ (1 << (ord - bba_pkg::MIN_BLOCK_ORDER));
      if (tags[bud] != bba_pkg::TAG_W'(ord)) break;
      if (bud < g) begin
        tags[g] = '0;
        g = bud;
      end else begin
        tags[bud] = '0;
      end
      ord++;
      tags[g] = bba_pkg::TAG_W'(ord);
    end
    rover = bba_pkg::GRAN_W'(g);
    foreach (live_offsets[i])
      if (live_offsets[i] == off) begin
        live_offsets.delete(i);
        break;
      end
    r = '{bba_pkg::ST_OK, '0, bba_pkg::ORD_W'(ord)};
    return r;
  endfunction

  function automatic int pick_gap(input int maxg);
    if (maxg == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    return $urandom_range(0, maxg);
  endfunction

  // one transfer on the request channel; prediction at acceptance
  task automatic send(input logic cmd, input logic [bba_pkg::REQ_W-1:0] req,
                      input logic [bba_pkg::OFF_W-1:0] rel, input bit typed,
                      input grant_t res);
    int gap;
    grant_t p;
    gap = pick_gap(tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_request_bytes <= req;
    in_release_offset <= rel;
    do @(posedge clk); while (in_stall);
    p = (cmd == bba_pkg::CMD_ALLOC) ? predict_alloc(req) : predict_release(rel);
    grants_due.push_back(typed ? res : p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_pool(input logic [bba_pkg::ORD_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_reset(v > bba_pkg::MAX_POOL_ORDER ? bba_pkg::MAX_POOL_ORDER :
               (v < bba_pkg::MIN_BLOCK_ORDER ? bba_pkg::MIN_BLOCK_ORDER : int'(v)));
  endtask

  task automatic random_items(input int count);
    int sel, top;
    logic [bba_pkg::REQ_W-1:0] req;
    logic [bba_pkg::OFF_W-1:0] rel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      top = $urandom_range(3, pool_ord);
      req = bba_pkg::REQ_W'($urandom_range(0, 1 << top));
      if ($urandom_range(0, 9) == 0) req = bba_pkg::REQ_W'($urandom);
      if (sel < 85 && sel >= 45 && live_offsets.size() != 0) begin
        rel = bba_pkg::OFF_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
        send(bba_pkg::CMD_FREE, bba_pkg::REQ_W'($urandom), rel, 0, '{0, 0, 0});
      end else if (sel >= 85) begin
        rel = bba_pkg::OFF_W'($urandom);
        if (sel >= 93)
          rel = bba_pkg::OFF_W'(bba_pkg::HEADER_BYTES +
                ($urandom_range(0, 63) << bba_pkg::MIN_BLOCK_ORDER));
        send(bba_pkg::CMD_FREE, bba_pkg::REQ_W'($urandom), rel, 0, '{0, 0, 0});
      end else begin
        send(bba_pkg::CMD_ALLOC, req, bba_pkg::OFF_W'($urandom), 0, '{0, 0, 0});
      end
    end
  endtask

  int stall_left = 0;
  always @(posedge clk) begin
    grant_t e;
    if (out_valid && !out_stall) begin
      if (grants_due.size() == 0) begin
        $display("%0t: result with none expected: %0d %0d %0d", $time,
                 out_status, out_payload_offset, out_granted_order);
        errors++;
      end else begin
        e = grants_due.pop_front();
        if (e.status !== out_status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          errors++;
        end
        if (e.offset !== out_payload_offset) begin
          $display("%0t: offset exp %0d got %0d", $time, e.offset, out_payload_offset);
          errors++;
        end
        if (e.order !== out_granted_order) begin
          $display("%0t: order exp %0d got %0d", $time, e.order, out_granted_order);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  stim_row_t rows[$] = '{
    '{bba_pkg::CMD_ALLOC, 16'd0,     16'd0,     1, '{bba_pkg::ST_OK, 16'd24, 5'd5}},
    '{bba_pkg::CMD_ALLOC, 16'hFFFF,  16'd0,     1, '{bba_pkg::ST_NOFIT, 16'd0, 5'd0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd0,     1, '{bba_pkg::ST_BADFREE, 16'd0, 5'd0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd25,    1, '{bba_pkg::ST_BADFREE, 16'd0, 5'd0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd24,    1, '{bba_pkg::ST_OK, 16'd0, 5'd16}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd24,    1, '{bba_pkg::ST_BADFREE, 16'd0, 5'd0}},
    '{bba_pkg::CMD_ALLOC, 16'd65512, 16'd0,     1, '{bba_pkg::ST_LAST, 16'd0, 5'd0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'hFFFF,  1, '{bba_pkg::ST_BADFREE, 16'd0, 5'd0}},
    '{bba_pkg::CMD_ALLOC, 16'd40,    16'd0,     0, '{0, 0, 0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd56,    0, '{0, 0, 0}},
    '{bba_pkg::CMD_ALLOC, 16'd8,     16'd0,     0, '{0, 0, 0}},
    '{bba_pkg::CMD_ALLOC, 16'd1000,  16'd0,     0, '{0, 0, 0}},
    '{bba_pkg::CMD_ALLOC, 16'd32744, 16'd0,     0, '{0, 0, 0}},
    '{bba_pkg::CMD_ALLOC, 16'd32744, 16'd0,     0, '{0, 0, 0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd88,    0, '{0, 0, 0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd24,    0, '{0, 0, 0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd32792, 0, '{0, 0, 0}},
    '{bba_pkg::CMD_ALLOC, 16'd7,     16'd0,     0, '{0, 0, 0}},
    '{bba_pkg::CMD_FREE,  16'd0,     16'd1048,  0, '{0, 0, 0}}
  };

  logic [bba_pkg::ORD_W-1:0] phase_ord[] =
    '{5'd0, 5'd6, 5'd8, 5'd31, 5'd10, 5'd5, 5'd7, 5'd9, 5'd16};
  int phase_len[] = '{40, 110, 110, 60, 110, 30, 110, 110, 60};

  initial begin
    pool_reset(bba_pkg::POOL_ORDER_RESET);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send(rows[i].cmd, rows[i].req, rows[i].rel, rows[i].typed, rows[i].res);
    foreach (phase_ord[p]) begin
      set_pool(phase_ord[p]);
      tx_gap_max = (p % 3 == 1) ? 0 : 3;
      random_items(phase_len[p]);
    end
    drain();
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
design/bba_pkg.sv
design/bba_front.sv
design/bba_queue.sv
design/bba_back.sv
design/buddy_block_allocator_top.sv
bench/buddy_block_allocator_top_tb.sv
